[src/pip_pkg.sv]
package pip_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_WIDTH_DEF  = 16;
    localparam int MIN_POLY_VERTICES = 2;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    typedef struct packed {
        logic valid;
        logic last;
    } edge_ctl_t;

    typedef struct packed {
        logic done;
        logic parity;
    } edge_res_t;

endpackage

[src/pip_if.sv]
interface pip_req_if #(
    parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    op;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;

    modport source (output valid, output op, output coord_x, output coord_y, input ready);
    modport sink (input valid, input op, input coord_x, input coord_y, output ready);
endinterface

interface pip_res_if;
    logic valid;
    logic ready;
    logic inside_res;
    logic vertices_dropped;

    modport source (output valid, output inside_res, output vertices_dropped, input ready);
    modport sink (input valid, input inside_res, input vertices_dropped, output ready);
endinterface

[src/point_in_polygon_test.sv]
// point-in-polygon test by crossing number
// req channel carries op, coord_x, coord_y: clear the polygon, append one
// vertex, or query one point. only a query gives a result on the res channel,
// carrying inside_res and vertices_dropped.
// clear and append leave the block idle; req is ready again on the next cycle.
// a query over n stored vertices (n >= 2) walks the polygon one vertex per
// cycle through the single read port of the vertex memory, feeding a
// three-stage edge unit (differences, two multipliers, compare); the result
// is registered once the edge unit signals done on the closing edge. fewer
// than two vertices gives outside. req.ready stays low during a query.
// appends beyond MAX_VERTICES are dropped and set vertices_dropped until the
// next clear. the vertex memory is not cleared; a fill count guards it.
// reset empties the polygon and the flag, no clearing pass is needed.
// if the receiver stalls, the result waits in the output register; the next
// query holds its result until that register is taken, and req stays low
// until then; requests before that query are still accepted.
module point_in_polygon_test #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
    parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    pip_req_if.sink    req,
    pip_res_if.source  res
);
    import pip_pkg::*;

    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam int MW     = 2 * COORD_WIDTH;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_FINISH = 3'd3;

    logic [2:0]  state_reg, state_next;
    logic [CNT_W-1:0]  count_reg;
    logic              ovf_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [ADDR_W-1:0] last_addr;
    logic              rd_valid_reg, rd_first_reg, rd_last_reg;
    logic              close_reg;
    logic              result_reg;
    logic              out_valid_reg, out_inside_reg, out_drop_reg;

    logic signed [COORD_WIDTH-1:0] px_reg, py_reg;
    logic signed [COORD_WIDTH-1:0] prev_x_reg, prev_y_reg, first_x_reg, first_y_reg;
    logic signed [COORD_WIDTH-1:0] rd_x, rd_y;

    logic          accept;
    logic          wr_en;
    logic          rd_en;
    logic [MW-1:0] rd_data;
    logic          edge_clear;
    logic          out_free;
    edge_ctl_t     edge_ctl;
    edge_res_t     edge_res;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid & req.ready;
    assign wr_en     = accept & (req.op == OP_APPEND) & (count_reg < CNT_W'(MAX_VERTICES));
    assign rd_en     = (state_reg == S_READ);
    assign last_addr = ADDR_W'(count_reg - CNT_W'(1));
    assign edge_clear = accept & (req.op == OP_QUERY);
    assign out_free  = ~out_valid_reg | res.ready;

    assign rd_x = $signed(rd_data[MW-1:COORD_WIDTH]);
    assign rd_y = $signed(rd_data[COORD_WIDTH-1:0]);

    pip_vertex_mem #(
        .DEPTH (MAX_VERTICES),
        .WIDTH (MW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data ({req.coord_x, req.coord_y}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data)
    );

    // edges in order, then the closing edge back to the first vertex
    assign edge_ctl.valid = (rd_valid_reg & ~rd_first_reg) | close_reg;
    assign edge_ctl.last  = close_reg;

    pip_edge_unit #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_edge (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (edge_clear),
        .ctl   (edge_ctl),
        .x1    (prev_x_reg),
        .y1    (prev_y_reg),
        .x2    (close_reg ? first_x_reg : rd_x),
        .y2    (close_reg ? first_y_reg : rd_y),
        .px    (px_reg),
        .py    (py_reg),
        .res   (edge_res)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && req.op == OP_QUERY)
                begin
                    if (count_reg < CNT_W'(MIN_POLY_VERTICES))
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                if (rd_addr_reg == last_addr)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (edge_res.done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            rd_addr_reg   <= '0;
            rd_valid_reg  <= 1'b0;
            rd_first_reg  <= 1'b0;
            rd_last_reg   <= 1'b0;
            close_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_en;
            rd_first_reg <= rd_en & (rd_addr_reg == '0);
            rd_last_reg  <= rd_en & (rd_addr_reg == last_addr);
            close_reg    <= rd_valid_reg & rd_last_reg;

            if (accept)
            begin
                case (req.op)
                    OP_CLEAR:
                    begin
                        count_reg <= '0;
                        ovf_reg   <= 1'b0;
                    end
                    OP_APPEND:
                    begin
                        if (wr_en)
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                    end
                    OP_QUERY:
                    begin
                        rd_addr_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (rd_en)
            begin
                rd_addr_reg <= rd_addr_reg + ADDR_W'(1);
            end

            if (state_reg == S_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (edge_clear)
        begin
            px_reg     <= req.coord_x;
            py_reg     <= req.coord_y;
            result_reg <= 1'b0;
        end
        else if (state_reg == S_DRAIN && edge_res.done)
        begin
            result_reg <= edge_res.parity;
        end

        if (rd_valid_reg)
        begin
            prev_x_reg <= rd_x;
            prev_y_reg <= rd_y;
            if (rd_first_reg)
            begin
                first_x_reg <= rd_x;
                first_y_reg <= rd_y;
            end
        end

        if (state_reg == S_FINISH && out_free)
        begin
            out_inside_reg <= result_reg;
            out_drop_reg   <= ovf_reg;
        end
    end

    assign res.valid            = out_valid_reg;
    assign res.inside_res       = out_inside_reg;
    assign res.vertices_dropped = out_drop_reg;
endmodule

[src/pip_vertex_mem.sv]
module pip_vertex_mem #(
    parameter int DEPTH = pip_pkg::MAX_VERTICES_DEF,
    parameter int WIDTH = 2 * pip_pkg::COORD_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

[src/pip_edge_unit.sv]
module pip_edge_unit #(
    parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  pip_pkg::edge_ctl_t            ctl,
    input  logic signed [COORD_WIDTH-1:0] x1,
    input  logic signed [COORD_WIDTH-1:0] y1,
    input  logic signed [COORD_WIDTH-1:0] x2,
    input  logic signed [COORD_WIDTH-1:0] y2,
    input  logic signed [COORD_WIDTH-1:0] px,
    input  logic signed [COORD_WIDTH-1:0] py,
    output pip_pkg::edge_res_t            res
);
    import pip_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] x1_ext, y1_ext, x2_ext, y2_ext, px_ext, py_ext;
    logic signed [DW-1:0] a_next, b_next, c_next, dy_next;
    logic                 act_next;

    edge_ctl_t            s1_ctl_reg;
    logic                 s1_act_reg;
    logic signed [DW-1:0] a_reg, b_reg, c_reg, dy_reg;

    edge_ctl_t            s2_ctl_reg;
    logic                 s2_act_reg;
    logic                 s2_neg_reg;
    logic signed [PW-1:0] l_reg, r_reg;

    logic                 hit;
    logic                 parity_reg;
    logic                 done_reg;

    assign x1_ext = $signed({x1[COORD_WIDTH-1], x1});
    assign y1_ext = $signed({y1[COORD_WIDTH-1], y1});
    assign x2_ext = $signed({x2[COORD_WIDTH-1], x2});
    assign y2_ext = $signed({y2[COORD_WIDTH-1], y2});
    assign px_ext = $signed({px[COORD_WIDTH-1], px});
    assign py_ext = $signed({py[COORD_WIDTH-1], py});

    assign a_next  = py_ext - y1_ext;
    assign b_next  = x2_ext - x1_ext;
    assign c_next  = px_ext - x1_ext;
    assign dy_next = y2_ext - y1_ext;
    // edge straddles the horizontal line through the point
    assign act_next = (y1 > py) != (y2 > py);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s1_act_reg <= 1'b0;
            s2_act_reg <= 1'b0;
            parity_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_ctl_reg <= ctl;
            s1_act_reg <= ctl.valid & act_next;
            s2_ctl_reg <= s1_ctl_reg;
            s2_act_reg <= s1_act_reg;
            done_reg   <= s2_ctl_reg.valid & s2_ctl_reg.last;
            if (clear)
            begin
                parity_reg <= 1'b0;
            end
            else
            begin
                parity_reg <= parity_reg ^ hit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        dy_reg     <= dy_next;
        l_reg      <= a_reg * b_reg;
        r_reg      <= c_reg * dy_reg;
        s2_neg_reg <= dy_reg[DW-1];
    end

    // crossing left of the point, sign of dy folded into the compare direction
    assign hit = s2_act_reg & (s2_neg_reg ? (l_reg > r_reg) : (l_reg < r_reg));

    assign res.done   = done_reg;
    assign res.parity = parity_reg;
endmodule

[test/tb.sv]
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pip_pkg::*;

    localparam int MAXV = MAX_VERTICES_DEF;
    localparam int CW   = COORD_WIDTH_DEF;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};

    localparam int RANDOM_ITEMS      = 1000;
    localparam int LONG_STALL_CYCLES = 400;
    localparam int IDLE_LIMIT        = 3000;
    localparam int DRAIN_CYCLES      = MAXV + 40;

    typedef struct packed {
        logic inside_res;
        logic vertices_dropped;
    } query_answer_t;

    logic clk;
    logic rst_n;

    pip_req_if #(.COORD_WIDTH(CW)) req_if ();
    pip_res_if res_if ();

    point_in_polygon_test #(
        .MAX_VERTICES (MAXV),
        .COORD_WIDTH  (CW)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .res   (res_if)
    );

    // predicted polygon state
    logic signed [CW-1:0] polygon_x [MAXV];
    logic signed [CW-1:0] polygon_y [MAXV];
    int unsigned          polygon_size;
    logic                 polygon_dropped;

    query_answer_t answers_due [$];
    int            mismatches;
    int            idle_cycles;
    int            burst_left;
    bit            gaps_on;
    bit            long_stall;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // exact crossing test: (py-y1)*(x2-x1)*sign(dy) < (px-x1)*|dy|
    function automatic logic edge_left_of(longint x1, longint y1, longint x2, longint y2,
                                          longint px, longint py);
        longint dy;
        longint lhs;
        longint rhs;
        dy  = y2 - y1;
        lhs = (py - y1) * (x2 - x1);
        rhs = (px - x1) * dy;
        if (dy < 0)
        begin
            lhs = -lhs;
            rhs = -rhs;
        end
        return lhs < rhs;
    endfunction

    function automatic logic ray_parity(logic signed [CW-1:0] px, logic signed [CW-1:0] py);
        logic   parity;
        int     j;
        longint y1;
        longint y2;
        parity = 1'b0;
        if (polygon_size < MIN_POLY_VERTICES)
            return 1'b0;
        for (int i = 0; i < polygon_size; i++)
        begin
            j  = (i + 1 == polygon_size) ? 0 : i + 1;
            y1 = polygon_y[i];
            y2 = polygon_y[j];
            if ((y1 > py) == (y2 > py))
                continue;
            if (edge_left_of(polygon_x[i], y1, polygon_x[j], y2, px, py))
                parity = ~parity;
        end
        return parity;
    endfunction

    function automatic void track_request(logic [1:0] op, logic signed [CW-1:0] x,
                                          logic signed [CW-1:0] y);
        query_answer_t answer;
        case (op)
            OP_CLEAR:
            begin
                polygon_size    = 0;
                polygon_dropped = 1'b0;
            end
            OP_APPEND:
            begin
                if (polygon_size < MAXV)
                begin
                    polygon_x[polygon_size] = x;
                    polygon_y[polygon_size] = y;
                    polygon_size++;
                end
                else
                    polygon_dropped = 1'b1;
            end
            OP_QUERY:
            begin
                answer.inside_res       = ray_parity(x, y);
                answer.vertices_dropped = polygon_dropped;
                answers_due.insert(answers_due.size(), answer);
            end
            default:
                ;
        endcase
    endfunction

    function automatic logic signed [CW-1:0] rand_coord(int spread, int centre);
        int v;
        if (spread == 0)
            v = $urandom;
        else
            v = centre + int'($urandom_range(0, 2 * spread)) - spread;
        return v[CW-1:0];
    endfunction

    task automatic send_request(input logic [1:0] op, input logic signed [CW-1:0] x,
                                input logic signed [CW-1:0] y);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 20);
            if (gap > 0)
            begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        req_if.valid   <= 1'b1;
        req_if.op      <= op;
        req_if.coord_x <= x;
        req_if.coord_y <= y;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        track_request(op, x, y);
    endtask

    task automatic wait_drained;
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (answers_due.size() != 0);
    endtask

    task automatic send_query(int spread, int centre);
        int                   k;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        k  = (polygon_size > 0) ? $urandom_range(0, polygon_size - 1) : 0;
        px = rand_coord(spread, centre);
        py = rand_coord(spread, centre);
        case ($urandom_range(0, 5))
            2:
            begin
                if (polygon_size > 0)
                begin
                    px = polygon_x[k];
                    py = polygon_y[k];
                end
            end
            3:
            begin
                if (polygon_size > 0)
                    py = polygon_y[k];
            end
            4:
            begin
                px = $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
                if ($urandom_range(0, 1))
                    py = $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
            end
            default:
                ;
        endcase
        send_request(OP_QUERY, px, py);
    endtask

    task automatic test_directed;
        // empty polygon, then one and two vertices
        send_request(OP_QUERY, 16'sd0, 16'sd0);
        send_request(OP_QUERY, COORD_MIN, COORD_MAX);
        send_request(OP_APPEND, 16'sd5, 16'sd5);
        send_request(OP_QUERY, 16'sd5, 16'sd5);
        send_request(OP_QUERY, 16'sd6, 16'sd4);
        send_request(OP_APPEND, COORD_MAX, COORD_MIN);
        send_request(OP_QUERY, 16'sd100, 16'sd0);
        send_request(OP_UNUSED, COORD_MAX, COORD_MAX);
        // square on the coordinate extremes
        send_request(OP_CLEAR, COORD_MIN, COORD_MIN);
        send_request(OP_APPEND, COORD_MIN, COORD_MIN);
        send_request(OP_APPEND, COORD_MAX, COORD_MIN);
        send_request(OP_APPEND, COORD_MAX, COORD_MAX);
        send_request(OP_APPEND, COORD_MIN, COORD_MAX);
        send_request(OP_QUERY, 16'sd0, 16'sd0);
        send_request(OP_QUERY, COORD_MIN, COORD_MIN);
        send_request(OP_QUERY, COORD_MAX, COORD_MAX);
        send_request(OP_QUERY, COORD_MAX, 16'sd0);
        send_request(OP_QUERY, COORD_MIN + 16'sd1, 16'sd0);
        // triangle queried on the height of its vertices and between them
        send_request(OP_CLEAR, 16'sd0, 16'sd0);
        send_request(OP_APPEND, 16'sd0, 16'sd0);
        send_request(OP_APPEND, 16'sd10, 16'sd10);
        send_request(OP_APPEND, -16'sd10, 16'sd10);
        send_request(OP_QUERY, 16'sd0, 16'sd0);
        send_request(OP_QUERY, 16'sd0, 16'sd5);
        send_request(OP_QUERY, 16'sd0, 16'sd10);
    endtask

    task automatic test_overflow;
        send_request(OP_CLEAR, 16'sd0, 16'sd0);
        for (int i = 0; i < MAXV; i++)
            send_request(OP_APPEND, rand_coord(4000, 0), rand_coord(4000, 0));
        send_query(4000, 0);
        send_request(OP_APPEND, COORD_MAX, COORD_MAX);
        send_request(OP_APPEND, COORD_MIN, COORD_MIN);
        send_query(4000, 0);
        send_query(4000, 0);
        send_request(OP_CLEAR, 16'sd0, 16'sd0);
        send_request(OP_QUERY, 16'sd0, 16'sd0);
    endtask

    task automatic test_pressure;
        send_request(OP_CLEAR, 16'sd0, 16'sd0);
        for (int i = 0; i < 40; i++)
            send_request(OP_APPEND, rand_coord(100, 0), rand_coord(100, 0));
        wait_drained();
        gaps_on    = 1'b0;
        long_stall = 1'b1;
        for (int i = 0; i < 12; i++)
            send_query(100, 0);
        gaps_on = 1'b1;
        wait_drained();
    endtask

    task automatic test_random;
        int items;
        int r;
        int nv;
        int spread;
        int centre;
        logic [1:0] op;
        items = 0;
        while (items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    nv = $urandom_range(0, 1);
                else if (r < 55)
                    nv = $urandom_range(3, 8);
                else if (r < 85)
                    nv = $urandom_range(9, 24);
                else if (r < 95)
                    nv = 2;
                else
                    nv = $urandom_range(MAXV - 4, MAXV + 6);
                case ($urandom_range(0, 3))
                    0: spread = 0;
                    1: spread = 8;
                    2: spread = 100;
                    default: spread = 4000;
                endcase
                centre = int'($urandom_range(0, 40000)) - 20000;
                send_request(OP_CLEAR, rand_coord(0, 0), rand_coord(0, 0));
                for (int i = 0; i < nv; i++)
                    send_request(OP_APPEND, rand_coord(spread, centre),
                                 rand_coord(spread, centre));
                r = $urandom_range(1, 10);
                for (int i = 0; i < r; i++)
                    send_query(spread, centre);
                items += 1 + nv + r;
            end
            else
            begin
                // noise, unused code included
                r = $urandom_range(1, 6);
                for (int i = 0; i < r; i++)
                begin
                    op = 2'($urandom_range(0, 3));
                    send_request(op, rand_coord(0, 0), rand_coord(0, 0));
                    if (op != OP_UNUSED)
                        items++;
                end
            end
        end
    endtask

    // receiver stall pattern
    initial
    begin
        logic [15:0] pattern;
        int          left;
        int          phase;
        bit          free_run;
        left     = 0;
        phase    = 0;
        pattern  = '1;
        free_run = 1'b1;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_stall)
            begin
                res_if.ready <= 1'b0;
                repeat (LONG_STALL_CYCLES) @(posedge clk);
                long_stall = 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    pattern  = 16'($urandom) | 16'h0001;
                    free_run = ($urandom_range(0, 3) == 0);
                    left     = $urandom_range(20, 200);
                end
                left--;
                res_if.ready <= free_run | pattern[phase];
                phase = (phase + 1) % 16;
            end
        end
    end

    always @(posedge clk)
    begin : check_answers
        query_answer_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (answers_due.size() == 0)
            begin
                $display("%0t: unexpected result inside_res=%0b vertices_dropped=%0b",
                         $time, res_if.inside_res, res_if.vertices_dropped);
                mismatches++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (res_if.inside_res !== want.inside_res)
                begin
                    $display("%0t: inside_res expected %0b actual %0b",
                             $time, want.inside_res, res_if.inside_res);
                    mismatches++;
                end
                if (res_if.vertices_dropped !== want.vertices_dropped)
                begin
                    $display("%0t: vertices_dropped expected %0b actual %0b",
                             $time, want.vertices_dropped, res_if.vertices_dropped);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("point_in_polygon_test test failed");
            $finish;
        end
    end

    initial
    begin
        mismatches      = 0;
        idle_cycles     = 0;
        burst_left      = 0;
        gaps_on         = 1'b1;
        long_stall      = 1'b0;
        polygon_size    = 0;
        polygon_dropped = 1'b0;
        rst_n          <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.op      <= OP_CLEAR;
        req_if.coord_x <= '0;
        req_if.coord_y <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_overflow();
        test_pressure();
        test_random();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && answers_due.size() == 0)
            $display("point_in_polygon_test test passed");
        else
            $display("point_in_polygon_test test failed");
        $finish;
    end

endmodule
